[sv/nand_flash_array_model_unit_defines.svh]
// ----------------------------------------------------------------------------
// NAND flash array model: assertion macros
// Clocked checks used by the unit RTL file; all are quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef NAND_FLASH_ARRAY_MODEL_UNIT_DEFINES_SVH
`define NAND_FLASH_ARRAY_MODEL_UNIT_DEFINES_SVH

// property must hold at every edge outside reset
`define NFAM_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define NFAM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[sv/nfam_pkg.sv]
// ----------------------------------------------------------------------------
// NAND flash array model: package
// Default geometry, command and status codes, controller states and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfam_pkg;

  localparam int unsigned DEF_SECTORS_PER_PAGE = 4;
  localparam int unsigned DEF_SECTOR_BYTES     = 512;
  localparam int unsigned DEF_SPARE_BYTES      = 64;
  localparam int unsigned DEF_PAGES_PER_BLOCK  = 64;
  localparam int unsigned DEF_NUM_BLOCKS       = 16;
  localparam int unsigned DEF_NUM_PLANES       = 2;

  localparam logic [15:0] NO_BLOCK  = 16'hFFFF;
  localparam logic [7:0]  NO_PAGE   = 8'hFF;
  localparam logic [7:0]  ERASED    = 8'hFF;
  localparam logic [14:0] COUNT_MAX = 15'h7FFF;

  typedef enum logic [2:0] {
    K_ERASE      = 3'd0,
    K_LOAD_READ  = 3'd1,
    K_LOAD_WRITE = 3'd2,
    K_PROGRAM    = 3'd3,
    K_WRITE_BYTE = 3'd4,
    K_READ_BYTE  = 3'd5,
    K_COPY       = 3'd6,
    K_REPROGRAM  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_BAD_BLOCK      = 3'd1,
    ST_CROSS_PLANE    = 3'd2,
    ST_NOT_OPEN_WRITE = 3'd3,
    ST_BAD_DEST       = 3'd4,
    ST_BAD_OFFSET     = 3'd5,
    ST_NOT_OPEN_READ  = 3'd6,
    ST_BAD_SOURCE     = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RDB, S_PLN1, S_PLN2, S_IDX, S_BASE, S_WALK, S_TAIL
  } state_t;

  typedef enum logic [1:0] {W_ERASE, W_LOAD, W_PROG} walk_t;

  function automatic logic [3:0] ones8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

endpackage

[sv/nfam_ram.sv]
// ----------------------------------------------------------------------------
// NAND flash array model: generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfam_ram #(
  parameter int unsigned      WIDTH = 8,
  parameter longint unsigned  DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/nand_flash_array_model_unit.sv]
// ----------------------------------------------------------------------------
// NAND flash array model unit
// Flash array and page register held in two RAMs, walked a byte per cycle.
// ----------------------------------------------------------------------------
// After reset the unit sweeps both RAMs to 0xFF, one byte a cycle, over all
// NUM_BLOCKS * PAGES_PER_BLOCK * PAGE_BYTES flash bytes (2162688 by default)
// with busy high. A command is taken when start is high and busy is low; its result
// shows for one cycle with done and cannot be held off. Write byte and commands
// rejected in the idle state give done on the next cycle and leave busy low,
// so they run one per cycle. Read byte passes through S_RDB. Load and program walk
// the page through the single flash RAM port pair at one byte a cycle, via S_IDX,
// S_BASE, S_WALK and S_TAIL; erase walks a whole block of PAGES_PER_BLOCK *
// PAGE_BYTES bytes; load write passes S_PLN1 and S_PLN2 first for the plane check, and
// copy is a load followed by a program.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nand_flash_array_model_unit_defines.svh"

module nand_flash_array_model_unit import nfam_pkg::*; #(
  parameter int unsigned SECTORS_PER_PAGE = DEF_SECTORS_PER_PAGE,
  parameter int unsigned SECTOR_BYTES     = DEF_SECTOR_BYTES,
  parameter int unsigned SPARE_BYTES      = DEF_SPARE_BYTES,
  parameter int unsigned PAGES_PER_BLOCK  = DEF_PAGES_PER_BLOCK,
  parameter int unsigned NUM_BLOCKS       = DEF_NUM_BLOCKS,
  parameter int unsigned NUM_PLANES       = DEF_NUM_PLANES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [15:0] blk,
  input  logic [7:0]  pg,
  input  logic [15:0] dest_blk,
  input  logic [7:0]  dest_pg,
  input  logic [11:0] byte_offset,
  input  logic [7:0]  wr_byte,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  rd_byte,
  output logic [14:0] set_bit_count
);

  localparam longint unsigned PAGE_BYTES =
    longint'(SECTORS_PER_PAGE) * longint'(SECTOR_BYTES) + longint'(SPARE_BYTES);
  localparam longint unsigned BLOCK_BYTES = longint'(PAGES_PER_BLOCK) * PAGE_BYTES;
  localparam longint unsigned FLASH_BYTES = longint'(NUM_BLOCKS) * BLOCK_BYTES;
  localparam int FA_W = $clog2(FLASH_BYTES);
  localparam int PR_W = $clog2(PAGE_BYTES);
  localparam int WI_W = $clog2(BLOCK_BYTES);
  localparam int PI_W = $clog2(longint'(NUM_BLOCKS) * longint'(PAGES_PER_BLOCK) + 1);
  localparam int PL_K = 20;
  localparam longint unsigned PL_M = (longint'(1) << PL_K) / longint'(NUM_PLANES);

  state_t          state, state_next;
  walk_t           walk, walk_next;
  logic            then_prog, then_prog_next;
  logic [15:0]     op_blk, op_dblk;
  logic [7:0]      op_pg;
  logic [7:0]      op_pg_dest;
  logic            op_src_ok;
  logic [15:0]     tgt_blk, tgt_blk_next;
  logic [7:0]      tgt_pg, tgt_pg_next;
  logic            tgt_we;
  logic            write_open;
  logic [PI_W-1:0] pidx;
  logic [FA_W-1:0] fa_addr, clr;
  logic [WI_W-1:0] idx;
  logic            pend;
  logic [FA_W-1:0] pend_fa;
  logic [PR_W-1:0] pend_pr;
  logic [14:0]     acc, acc_sum;
  logic [15:0]     q_s, q_d, r_s, r_d;
  logic            res_v, res_rd;
  status_t         res_st;
  logic [14:0]     res_cnt;
  logic            pr_we_byte;

  logic            blk_in_ok, src_in_ok, dst_in_ok, tgt_ok, tgt_any, off_bad;
  logic [PR_W-1:0] off_idx;
  logic [15:0]     sel_b;
  logic [7:0]      sel_p;
  logic [15:0]     sum_w;

  logic            fl_we, pr_we;
  logic [FA_W-1:0] fl_waddr;
  logic [7:0]      fl_wdata, fl_rdata, pr_wdata, pr_rdata;
  logic [PR_W-1:0] pr_waddr, pr_raddr;

  assign blk_in_ok = 32'(blk) < NUM_BLOCKS;
  assign src_in_ok = blk_in_ok && (32'(pg) < PAGES_PER_BLOCK);
  assign dst_in_ok = (32'(dest_blk) < NUM_BLOCKS) && (32'(dest_pg) < PAGES_PER_BLOCK);
  assign tgt_ok    = (32'(tgt_blk) < NUM_BLOCKS) && (32'(tgt_pg) < PAGES_PER_BLOCK);
  assign tgt_any   = (32'(tgt_blk) < NUM_BLOCKS) || (32'(tgt_pg) < PAGES_PER_BLOCK);
  assign off_bad   = 64'(byte_offset) >= PAGE_BYTES;
  assign off_idx   = PR_W'(byte_offset);
  assign busy      = (state != S_IDLE);

  always_comb begin
    r_s = 16'(op_blk - 16'(32'(q_s) * NUM_PLANES));
    r_d = 16'(op_dblk - 16'(32'(q_d) * NUM_PLANES));
    if (32'(r_s) >= NUM_PLANES) begin
      r_s = 16'(r_s - 16'(NUM_PLANES));
    end
    if (32'(r_d) >= NUM_PLANES) begin
      r_d = 16'(r_d - 16'(NUM_PLANES));
    end
  end

  always_comb begin
    sum_w = 16'(acc) + 16'(ones8(pr_rdata & ~fl_rdata));
    if (pend && walk == W_PROG) begin
      acc_sum = (sum_w > 16'(COUNT_MAX)) ? COUNT_MAX : sum_w[14:0];
    end else begin
      acc_sum = acc;
    end
  end

  always_comb begin
    state_next     = state;
    walk_next      = walk;
    then_prog_next = then_prog;
    tgt_we         = 1'b0;
    tgt_blk_next   = tgt_blk;
    tgt_pg_next    = tgt_pg;
    res_v          = 1'b0;
    res_st         = ST_OK;
    res_rd         = 1'b0;
    res_cnt        = '0;
    pr_we_byte     = 1'b0;
    unique case (state)
      S_CLR: begin
        if (clr == FA_W'(FLASH_BYTES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (kind_t'(kind))
            K_ERASE: begin
              if (!blk_in_ok) begin
                res_v = 1'b1; res_st = ST_BAD_BLOCK;
              end else begin
                walk_next = W_ERASE; state_next = S_IDX;
              end
            end
            K_LOAD_READ: begin
              if (!src_in_ok) begin
                res_v = 1'b1; res_st = ST_BAD_SOURCE;
              end else begin
                tgt_we = 1'b1; tgt_blk_next = NO_BLOCK; tgt_pg_next = NO_PAGE;
                walk_next = W_LOAD; then_prog_next = 1'b0; state_next = S_IDX;
              end
            end
            K_LOAD_WRITE: begin
              then_prog_next = 1'b0; state_next = S_PLN1;
            end
            K_PROGRAM: begin
              if (!tgt_ok) begin
                res_v = 1'b1; res_st = write_open ? ST_BAD_DEST : ST_NOT_OPEN_WRITE;
              end else begin
                walk_next = W_PROG; state_next = S_IDX;
              end
            end
            K_WRITE_BYTE: begin
              res_v = 1'b1;
              if (off_bad) res_st = ST_BAD_OFFSET;
              else if (!tgt_ok) res_st = ST_NOT_OPEN_WRITE;
              else pr_we_byte = 1'b1;
            end
            K_READ_BYTE: begin
              if (off_bad) begin
                res_v = 1'b1; res_st = ST_BAD_OFFSET;
              end else if (tgt_any) begin
                res_v = 1'b1; res_st = ST_NOT_OPEN_READ;
              end else begin
                state_next = S_RDB;
              end
            end
            K_COPY: begin
              if (!src_in_ok) begin
                res_v = 1'b1; res_st = ST_BAD_SOURCE;
              end else if (!dst_in_ok) begin
                res_v = 1'b1; res_st = ST_BAD_DEST;
              end else begin
                then_prog_next = 1'b1; state_next = S_PLN1;
              end
            end
            K_REPROGRAM: begin
              if (!src_in_ok) begin
                res_v = 1'b1; res_st = ST_BAD_DEST;
              end else begin
                tgt_we = 1'b1; tgt_blk_next = blk; tgt_pg_next = pg;
                walk_next = W_PROG; state_next = S_IDX;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RDB: begin
        res_v = 1'b1; res_rd = 1'b1; state_next = S_IDLE;
      end
      S_PLN1: state_next = S_PLN2;
      S_PLN2: begin
        if (r_s != r_d) begin
          res_v = 1'b1; res_st = ST_CROSS_PLANE; state_next = S_IDLE;
        end else if (!op_src_ok) begin
          res_v = 1'b1; res_st = ST_BAD_SOURCE; state_next = S_IDLE;
        end else begin
          tgt_we = 1'b1; tgt_blk_next = op_dblk; tgt_pg_next = 8'(op_pg_dest);
          walk_next = W_LOAD; state_next = S_IDX;
        end
      end
      S_IDX:  state_next = S_BASE;
      S_BASE: state_next = S_WALK;
      S_WALK: begin
        if (walk == W_ERASE) begin
          if (idx == WI_W'(BLOCK_BYTES - 1)) state_next = S_TAIL;
        end else if (idx == WI_W'(PAGE_BYTES - 1)) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        if (walk == W_LOAD && then_prog) begin
          walk_next = W_PROG; then_prog_next = 1'b0; state_next = S_IDX;
        end else begin
          res_v = 1'b1;
          if (walk == W_PROG) begin
            res_cnt = acc_sum;
            tgt_we = 1'b1; tgt_blk_next = NO_BLOCK; tgt_pg_next = NO_PAGE;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      walk       <= W_ERASE;
      then_prog  <= 1'b0;
      tgt_blk    <= NO_BLOCK;
      tgt_pg     <= NO_PAGE;
      write_open <= 1'b0;
      clr        <= '0;
      pend       <= 1'b0;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      walk      <= walk_next;
      then_prog <= then_prog_next;
      if (tgt_we) begin
        tgt_blk    <= tgt_blk_next;
        tgt_pg     <= tgt_pg_next;
        write_open <= (tgt_blk_next != NO_BLOCK) && (tgt_pg_next != NO_PAGE);
      end
      if (state == S_CLR) clr <= clr + 1'b1;
      pend <= (state == S_WALK) && (walk != W_ERASE);
      done <= res_v;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_blk     <= blk;
      op_pg      <= pg;
      op_dblk    <= dest_blk;
      op_pg_dest <= dest_pg;
      op_src_ok  <= src_in_ok;
    end
    if (state == S_PLN1) begin
      q_s <= 16'((40'(op_blk) * 40'(PL_M)) >> PL_K);
      q_d <= 16'((40'(op_dblk) * 40'(PL_M)) >> PL_K);
    end
    if (state == S_IDX) begin
      pidx <= PI_W'(32'(sel_b) * 32'(PAGES_PER_BLOCK) + 32'(sel_p));
    end
    if (state == S_BASE) begin
      fa_addr <= FA_W'(64'(pidx) * 64'(PAGE_BYTES));
      idx     <= '0;
      acc     <= '0;
    end else if (state == S_WALK) begin
      fa_addr <= fa_addr + 1'b1;
      idx     <= idx + 1'b1;
      acc     <= acc_sum;
    end else begin
      acc     <= acc_sum;
    end
    pend_fa       <= fa_addr;
    pend_pr       <= idx[PR_W-1:0];
    status        <= res_st;
    rd_byte       <= res_rd ? pr_rdata : 8'h00;
    set_bit_count <= res_cnt;
  end

  always_comb begin
    sel_b = op_blk;
    sel_p = op_pg;
    unique case (walk)
      W_PROG:  begin sel_b = tgt_blk; sel_p = tgt_pg; end
      W_ERASE: sel_p = 8'h00;
      W_LOAD:  sel_p = op_pg;
      default: sel_p = op_pg;
    endcase
  end

  always_comb begin
    fl_we    = (state == S_CLR) || (state == S_WALK && walk == W_ERASE)
               || (pend && walk == W_PROG);
    fl_waddr = (state == S_CLR) ? clr : (pend ? pend_fa : fa_addr);
    fl_wdata = (pend && walk == W_PROG) ? pr_rdata : ERASED;
    pr_we    = (state == S_CLR && 64'(clr) < PAGE_BYTES) || (pend && walk == W_LOAD)
               || pr_we_byte;
    if (state == S_CLR) begin
      pr_waddr = clr[PR_W-1:0];
      pr_wdata = ERASED;
    end else if (pend) begin
      pr_waddr = pend_pr;
      pr_wdata = fl_rdata;
    end else begin
      pr_waddr = off_idx;
      pr_wdata = wr_byte;
    end
    pr_raddr = (state == S_WALK) ? idx[PR_W-1:0] : off_idx;
  end

  nfam_ram #(.WIDTH(8), .DEPTH(FLASH_BYTES)) u_flash (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fa_addr),
    .rdata (fl_rdata)
  );

  nfam_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_preg (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  `NFAM_CHECK(a_fail_no_count, done && status != ST_OK |-> set_bit_count == 15'd0, "count on failed transaction")
  `NFAM_CHECK(a_rd_only_ok, done && rd_byte != 8'h00 |-> status == ST_OK, "read data on failed transaction")
  `NFAM_CHECK(a_open_flag, write_open == (tgt_blk != NO_BLOCK && tgt_pg != NO_PAGE), "open flag out of step with target")
  `NFAM_NEVER(a_prog_overlap, state == S_WALK && pend && walk == W_PROG && fl_waddr == fa_addr, "flash read and write collide")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// NAND flash array model unit: self-checking testbench
// Drives command transactions through the start/busy handshake and checks
// each done result against a byte-exact model of the array and page register.
// A directed part covers the edge cases; random write, read and copy sessions
// with noise follow, under three sender idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import nfam_pkg::*;

  localparam int unsigned PAGE_BYTES = DEF_SECTORS_PER_PAGE * DEF_SECTOR_BYTES +
                                       DEF_SPARE_BYTES;
  localparam int unsigned NPAGES     = DEF_PAGES_PER_BLOCK;
  localparam int unsigned NBLOCKS    = DEF_NUM_BLOCKS;
  localparam int unsigned NPLANES    = DEF_NUM_PLANES;
  localparam int unsigned ARRAY_BYTES = NBLOCKS * NPAGES * PAGE_BYTES;

  typedef struct {
    status_t     st;
    logic [7:0]  rd;
    logic [14:0] cnt;
  } flash_result_t;

  class flash_scoreboard;
    bit [7:0]      cells[];
    bit [7:0]      page_reg[PAGE_BYTES];
    bit            wr_open;
    bit [15:0]     tgt_blk;
    bit [7:0]      tgt_pg;
    flash_result_t pending[$];
    int            errors;
    int            results;
    int            kind_seen[8];

    function new();
      cells = new[ARRAY_BYTES];
      foreach (cells[i]) cells[i] = ERASED;
      foreach (page_reg[i]) page_reg[i] = ERASED;
      set_tgt(NO_BLOCK, NO_PAGE);
      errors = 0;
      results = 0;
    endfunction

    function bit in_range(bit [15:0] b, bit [7:0] p);
      return b < NBLOCKS && p < NPAGES;
    endfunction

    function int unsigned base_of(bit [15:0] b, bit [7:0] p);
      return (b * NPAGES + p) * PAGE_BYTES;
    endfunction

    function void set_tgt(bit [15:0] b, bit [7:0] p);
      tgt_blk = b;
      tgt_pg  = p;
      wr_open = (b != NO_BLOCK) && (p != NO_PAGE);
    endfunction

    function void fetch(bit [15:0] b, bit [7:0] p);
      int unsigned base;
      base = base_of(b, p);
      for (int i = 0; i < PAGE_BYTES; i++) page_reg[i] = cells[base + i];
    endfunction

    function bit [14:0] rising_bits();
      int unsigned n;
      int unsigned base;
      bit [7:0] v;
      n = 0;
      if (!in_range(tgt_blk, tgt_pg)) return '0;
      base = base_of(tgt_blk, tgt_pg);
      for (int i = 0; i < PAGE_BYTES; i++) begin
        v = page_reg[i] & ~cells[base + i];
        n += $countones(v);
      end
      return (n > COUNT_MAX) ? COUNT_MAX : n[14:0];
    endfunction

    function status_t commit(output bit [14:0] cnt);
      int unsigned base;
      cnt = rising_bits();
      if (!wr_open) return ST_NOT_OPEN_WRITE;
      if (!in_range(tgt_blk, tgt_pg)) return ST_BAD_DEST;
      base = base_of(tgt_blk, tgt_pg);
      for (int i = 0; i < PAGE_BYTES; i++) cells[base + i] = page_reg[i];
      set_tgt(NO_BLOCK, NO_PAGE);
      return ST_OK;
    endfunction

    function void note(kind_t k, bit [15:0] b, bit [7:0] p, bit [15:0] db, bit [7:0] dp,
                       bit [11:0] off, bit [7:0] wb);
      flash_result_t r;
      bit [14:0] c;
      r.st = ST_OK;
      r.rd = '0;
      r.cnt = '0;
      kind_seen[k]++;
      case (k)
        K_ERASE: begin
          if (b >= NBLOCKS) r.st = ST_BAD_BLOCK;
          else for (int i = 0; i < NPAGES * PAGE_BYTES; i++)
            cells[base_of(b, 0) + i] = ERASED;
        end
        K_LOAD_READ: begin
          if (!in_range(b, p)) r.st = ST_BAD_SOURCE;
          else begin
            set_tgt(NO_BLOCK, NO_PAGE);
            fetch(b, p);
          end
        end
        K_LOAD_WRITE: begin
          if (b % NPLANES != db % NPLANES) r.st = ST_CROSS_PLANE;
          else if (!in_range(b, p)) r.st = ST_BAD_SOURCE;
          else begin
            set_tgt(db, dp);
            fetch(b, p);
          end
        end
        K_PROGRAM: begin
          r.st = commit(c);
          r.cnt = c;
        end
        K_WRITE_BYTE: begin
          if (off >= PAGE_BYTES) r.st = ST_BAD_OFFSET;
          else if (!in_range(tgt_blk, tgt_pg)) r.st = ST_NOT_OPEN_WRITE;
          else page_reg[off] = wb;
        end
        K_READ_BYTE: begin
          if (off >= PAGE_BYTES) r.st = ST_BAD_OFFSET;
          else if (tgt_blk < NBLOCKS || tgt_pg < NPAGES) r.st = ST_NOT_OPEN_READ;
          else r.rd = page_reg[off];
        end
        K_COPY: begin
          if (!in_range(b, p)) r.st = ST_BAD_SOURCE;
          else if (!in_range(db, dp)) r.st = ST_BAD_DEST;
          else if (b % NPLANES != db % NPLANES) r.st = ST_CROSS_PLANE;
          else begin
            set_tgt(db, dp);
            fetch(b, p);
            r.st = commit(c);
            r.cnt = c;
          end
        end
        default: begin
          if (!in_range(b, p)) r.st = ST_BAD_DEST;
          else begin
            set_tgt(b, p);
            r.st = commit(c);
            r.cnt = c;
          end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    function void check(logic [2:0] st, logic [7:0] rd, logic [14:0] cnt);
      flash_result_t e;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status=%0d rd=%0h cnt=%0d", st, rd, cnt));
        return;
      end
      e = pending.pop_front();
      if (st !== e.st) report($sformatf("status %0d, want %0d", st, e.st));
      if (rd !== e.rd) report($sformatf("rd_byte %0h, want %0h", rd, e.rd));
      if (cnt !== e.cnt) report($sformatf("set_bit_count %0d, want %0d", cnt, e.cnt));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind = '0;
  logic [15:0] blk = '0;
  logic [7:0]  pg = '0;
  logic [15:0] dest_blk = '0;
  logic [7:0]  dest_pg = '0;
  logic [11:0] byte_offset = '0;
  logic [7:0]  wr_byte = '0;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  rd_byte;
  logic [14:0] set_bit_count;

  flash_scoreboard sb = new();
  int idle_pct = 0;
  int sent = 0;
  int erase_budget = 3;

  nand_flash_array_model_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .blk(blk), .pg(pg), .dest_blk(dest_blk), .dest_pg(dest_pg),
    .byte_offset(byte_offset), .wr_byte(wr_byte),
    .done(done), .status(status), .rd_byte(rd_byte), .set_bit_count(set_bit_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check(status, rd_byte, set_bit_count);
  end

  task automatic send(kind_t k, bit [15:0] b, bit [7:0] p, bit [15:0] db, bit [7:0] dp,
                      bit [11:0] off, bit [7:0] wb);
    start       <= 1'b1;
    kind        <= k;
    blk         <= b;
    pg          <= p;
    dest_blk    <= db;
    dest_pg     <= dp;
    byte_offset <= off;
    wr_byte     <= wb;
    do @(posedge clk); while (busy);
    sb.note(k, b, p, db, dp, off, wb);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic bit [15:0] any_blk();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, NBLOCKS - 1);
    if (r < 89) return NO_BLOCK;
    return $urandom_range(0, 65535);
  endfunction

  function automatic bit [7:0] any_pg();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, NPAGES - 1);
    if (r < 89) return NO_PAGE;
    return $urandom_range(0, 255);
  endfunction

  function automatic bit [11:0] any_off();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, PAGE_BYTES - 1);
    if (r < 85) return PAGE_BYTES - 1;
    if (r < 90) return PAGE_BYTES;
    return $urandom_range(0, 4095);
  endfunction

  task automatic random_phase(int target);
    bit [15:0] b;
    bit [15:0] db;
    int r;
    while (sent < target) begin
      r = $urandom_range(0, 99);
      b = $urandom_range(0, NBLOCKS - 1);
      db = $urandom_range(0, NBLOCKS / NPLANES - 1) * NPLANES + b % NPLANES;
      if (r < 30) begin
        send(K_LOAD_WRITE, b, $urandom_range(0, NPAGES - 1), db,
             ($urandom_range(0, 9) == 0) ? any_pg() : $urandom_range(0, NPAGES - 1),
             '0, '0);
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 7) == 0) send(K_READ_BYTE, '0, '0, '0, '0, any_off(), '0);
          else send(K_WRITE_BYTE, '0, '0, '0, '0, any_off(), $urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < 85) send(K_PROGRAM, '0, '0, '0, '0, '0, '0);
        else send(K_REPROGRAM, any_blk(), any_pg(), '0, '0, '0, '0);
      end else if (r < 50) begin
        send(K_LOAD_READ, any_blk(), any_pg(), '0, '0, '0, '0);
        repeat ($urandom_range(1, 6)) send(K_READ_BYTE, '0, '0, '0, '0, any_off(), '0);
      end else if (r < 60) begin
        send(K_COPY, any_blk(), any_pg(),
             ($urandom_range(0, 4) == 0) ? any_blk() : db, any_pg(), '0, '0);
      end else if (r < 98) begin
        send(kind_t'($urandom_range(1, 7)), any_blk(), any_pg(),
             $urandom_range(0, 65535), $urandom_range(0, 255),
             $urandom_range(0, 4095), $urandom_range(0, 255));
      end else begin
        if (erase_budget > 0 && $urandom_range(0, 3) == 0) begin
          erase_budget--;
          send(K_ERASE, b, '0, '0, '0, '0, '0);
        end else begin
          send(K_ERASE, $urandom_range(NBLOCKS, 65535), $urandom_range(0, 255), '0, '0,
               '0, '0);
        end
      end
    end
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed edge cases
    send(K_LOAD_READ,  0, 0, 0, 0, 0, 0);
    send(K_READ_BYTE,  0, 0, 0, 0, 0, 0);
    send(K_READ_BYTE,  0, 0, 0, 0, PAGE_BYTES - 1, 0);
    send(K_READ_BYTE,  0, 0, 0, 0, PAGE_BYTES, 0);
    send(K_WRITE_BYTE, 0, 0, 0, 0, 12'hFFF, 8'hFF);
    send(K_WRITE_BYTE, 0, 0, 0, 0, 0, 8'hA5);
    send(K_LOAD_WRITE, 0, 0, 1, 0, 0, 0);
    send(K_LOAD_WRITE, 16, 0, 0, 0, 0, 0);
    send(K_LOAD_WRITE, 0, 8'hFF, 2, 5, 0, 0);
    send(K_LOAD_WRITE, 0, 0, 2, 5, 0, 0);
    send(K_WRITE_BYTE, 0, 0, 0, 0, 0, 8'h00);
    send(K_WRITE_BYTE, 0, 0, 0, 0, PAGE_BYTES - 1, 8'h5A);
    send(K_READ_BYTE,  0, 0, 0, 0, 1, 0);
    send(K_PROGRAM,    0, 0, 0, 0, 0, 0);
    send(K_PROGRAM,    0, 0, 0, 0, 0, 0);
    send(K_LOAD_WRITE, 1, 63, NO_BLOCK, 3, 0, 0);
    send(K_WRITE_BYTE, 0, 0, 0, 0, 7, 8'h11);
    send(K_LOAD_WRITE, 0, 1, 20, 3, 0, 0);
    send(K_PROGRAM,    0, 0, 0, 0, 0, 0);
    send(K_REPROGRAM,  16, 0, 0, 0, 0, 0);
    send(K_REPROGRAM,  2, 5, 0, 0, 0, 0);
    send(K_COPY,       2, 64, 4, 1, 0, 0);
    send(K_COPY,       2, 5, 4, 64, 0, 0);
    send(K_COPY,       2, 5, 5, 1, 0, 0);
    send(K_COPY,       2, 5, 4, 1, 0, 0);
    send(K_ERASE,      NO_BLOCK, 0, 0, 0, 0, 0);
    send(K_ERASE,      2, 0, 0, 0, 0, 0);

    idle_pct = 31;
    random_phase(sent + 450);
    idle_pct = 83;
    random_phase(sent + 450);
    idle_pct = 0;
    random_phase(sent + 450);
    start <= 1'b0;

    guard = 0;
    while (sb.pending.size() != 0 && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    repeat (200) @(posedge clk);

    $display("covered %0d transactions, %0d results", sent, sb.results);
    $display("per kind: erase %0d load_rd %0d load_wr %0d prog %0d wr %0d rd %0d copy %0d reprog %0d",
             sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
             sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6], sb.kind_seen[7]);
    if (sb.pending.size() != 0) sb.report($sformatf("%0d results missing", sb.pending.size()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
